/* rtl/sha_pkg.sv */
// SHA-256 engine package: round constants, initial hash words, command types, rotate helper.
// No dependencies; used by the controller, datapath and top level.
package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Controller-to-datapath command group.
  typedef struct packed {
    logic       put_byte;   // write byte_val at the current block position
    logic [7:0] byte_val;
    logic       add_len;    // count 8 more message bits
    logic       put_len;    // place bit length in words 14 and 15
    logic       load_work;  // copy hash into working variables
    logic       round;      // run one round
    logic [5:0] round_idx;
    logic       fold;       // add working variables into hash
    logic       reset_msg;  // restore initial hash, clear counters
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] byte_cnt;
  } sha_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha_stream_if.sv */
// Valid/ready channel interface with a parameterized payload type.
// No dependencies.
interface sha_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sha_datapath.sv */
// SHA-256 datapath: block words, schedule, working variables, hash, bit length.
// Depends on sha_pkg.
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  output sha_sts_t    sts,
  input  logic [2:0]  rd_idx,
  output logic [31:0] rd_word
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [5:0]  cnt_r;
  logic [63:0] len_r;

  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [31:0] x15, x2, s0, s1, wnew, wt, t1, t2;
  logic [3:0]  ti;

  assign wi = cnt_r[5:2];
  assign sh = 5'd24 - {cnt_r[1:0], 3'b000};
  assign ti = cmd.round_idx[3:0];
  assign x15 = w_r[ti + 4'd1];
  assign x2  = w_r[ti + 4'd14];
  assign s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign wnew = w_r[ti] + s0 + w_r[ti + 4'd9] + s1;
  assign wt = cmd.round_idx[5:4] == 2'd0 ? w_r[ti] : wnew;
  assign t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[cmd.round_idx] + wt;
  assign t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign sts.byte_cnt = cnt_r;
  assign rd_word = h_r[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      if (cnt_r[1:0] == 2'd0) w_r[wi] <= {cmd.byte_val, 24'd0};
      else w_r[wi] <= w_r[wi] | ({24'd0, cmd.byte_val} << sh);
    end
    if (cmd.put_len) begin
      w_r[14] <= len_r[63:32];
      w_r[15] <= len_r[31:0];
    end
    if (cmd.round) begin
      w_r[ti] <= wt;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
    if (cmd.load_work) begin
      for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_msg) begin
      for (int j = 0; j < 8; j++) h_r[j] <= INIT_HASH[j];
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
      end
      if (cmd.put_byte) cnt_r <= cnt_r + 6'd1;
      if (cmd.put_len) cnt_r <= '0;
      if (cmd.add_len) len_r <= len_r + 64'd8;
    end
  end

endmodule

/* rtl/sha_ctrl.sv */
// SHA-256 controller: byte intake, padding, 64-round sequencing, digest output.
// Depends on sha_pkg.
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_has,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_idx,
  output sha_cmd_t   cmd,
  input  sha_sts_t   sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;   // message end: pad after this block
  logic       pad_r, pad_nxt;   // 0x80 marker byte still owed
  logic       lenb_r, lenb_nxt; // block in flight carries the length

  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign out_valid = state_r == ST_OUT;
  assign out_idx   = idx_r;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    pad_nxt   = pad_r;
    lenb_nxt  = lenb_r;
    cmd       = '0;
    cmd.round_idx = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.put_byte = in_has;
          cmd.byte_val = in_data;
          cmd.add_len  = in_has;
          if (in_has && sts.byte_cnt == 6'd63) begin
            state_nxt = ST_LOAD;
            fin_nxt   = in_last;
            pad_nxt   = in_last;
          end else if (in_last) begin
            state_nxt = ST_PAD;
            pad_nxt   = 1'b1;
          end
        end
      end
      ST_PAD: begin
        // place the marker first, then zeros until position 56, then the length
        cmd.byte_val = pad_r ? PAD_BYTE : 8'h00;
        if (pad_r || sts.byte_cnt != 6'd56) begin
          cmd.put_byte = 1'b1;
          pad_nxt      = 1'b0;
          if (sts.byte_cnt == 6'd63) begin
            state_nxt = ST_LOAD;
            fin_nxt   = 1'b1;
          end
        end else begin
          cmd.put_len = 1'b1;
          lenb_nxt    = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_work = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (lenb_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
          lenb_nxt  = 1'b0;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
          fin_nxt   = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reset_msg = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      lenb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      lenb_r  <= lenb_nxt;
    end
  end

endmodule

/* rtl/sha256_hash_engine_core.sv */
// SHA-256 byte-stream hash engine, top level.
// Flow: a byte that fills a block starts a compression (load, 64 rounds, fold) on the single
// shared round unit, and no bytes are taken until it ends. End of message adds padding bytes
// (marker, zeros, length; an extra block when the length spills) and one or two compressions,
// then eight digest word transfers. Reset: synchronous active-low rst_n returns control to
// idle, hash to init.
module sha256_hash_engine_core
  import sha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [2:0]  out_idx;
  logic [31:0] rd_word;

  // The controller owns handshakes; padding bytes ride the same byte write path.
  sha_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.payload.data_byte),
    .in_has   (in_ch.payload.has_byte),
    .in_last  (in_ch.payload.last_byte),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_idx,
    .cmd, .sts
  );

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .rd_idx (out_idx),
    .rd_word
  );

  // Digest words are read straight from the hash registers, held while out is stalled.
  assign out_ch.payload.digest_word = rd_word;
  assign out_ch.payload.word_index  = out_idx;
  assign out_ch.payload.last_word   = out_idx == 3'd7;

endmodule

/* rtl/sha256_hash_engine_checker.sv */
// Port-level checker for the SHA-256 engine, bound to the top level.
// No package dependency.
module sha256_hash_engine_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word,
  input logic [31:0] digest_word
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last_word mismatch");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && word_index != 3'd7
      |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest word order");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digest_word)) else $error("stall lost");
endmodule

bind sha256_hash_engine_core sha256_hash_engine_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_index(out_ch.payload.word_index),
  .last_word(out_ch.payload.last_word),
  .digest_word(out_ch.payload.digest_word)
);

/* bench/sha_tb_pkg.sv */
// Transfer payload types for the SHA-256 engine bench: one message byte in, one digest word out.
// Depends on nothing; used by the checker and the testbench top.
package sha_tb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

endpackage

/* bench/sha256_digest_checker.sv */
// Watches the byte and digest channels, computes SHA-256 digests on its own and compares.
// Depends on sha_pkg (round constants, initial hash) and sha_tb_pkg (payload types).
module sha256_digest_checker
  import sha_pkg::*;
  import sha_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  msg_item_t    in_item,
  input  logic         out_valid,
  input  logic         out_ready,
  input  digest_item_t out_item,
  output int           words_pending,
  output int           error_count,
  output int           digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]  hash_state [8];
  logic [31:0]  block_words [16];
  int unsigned  block_fill;
  logic [63:0]  msg_bits;
  digest_item_t digest_queue [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_words();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = block_words[t];
      end else begin
        s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void pack_byte(input logic [7:0] b);
    int unsigned wi;
    wi = block_fill >> 2;
    if ((block_fill & 3) == 0) block_words[wi] = '0;
    block_words[wi] |= 32'(b) << (24 - 8 * (block_fill & 3));
    block_fill++;
    if (block_fill == 64) begin
      block_fill = 0;
      compress_words();
    end
  endfunction

  function automatic void restart_message();
    for (int j = 0; j < 8; j++) hash_state[j] = INIT_HASH[j];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // Absorb one accepted byte transfer; on end of message pad, finish and queue the digest.
  function automatic void absorb_item(input msg_item_t it);
    digest_item_t d;
    if (it.has_byte) begin
      pack_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (it.last_byte) begin
      pack_byte(PAD_BYTE);
      while (block_fill != 56) pack_byte(8'h00);
      block_words[14] = msg_bits[63:32];
      block_words[15] = msg_bits[31:0];
      block_fill = 0;
      compress_words();
      for (int j = 0; j < 8; j++) begin
        d.digest_word = hash_state[j];
        d.word_index  = 3'(j);
        d.last_word   = (j == 7);
        digest_queue.push_back(d);
      end
      restart_message();
    end
  endfunction

  assign words_pending = digest_queue.size();

  always @(posedge clk) begin
    digest_item_t want;
    if (!rst_n) begin
      restart_message();
      digest_queue.delete();
      error_count  <= 0;
      digests_seen <= 0;
    end else begin
      if (in_valid && in_ready) absorb_item(in_item);
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest transfer, expected none, actual %h/%0d/%0d",
                   $time, out_item.digest_word, out_item.word_index, out_item.last_word);
          error_count <= error_count + 1;
        end else begin
          want = digest_queue.pop_front();
          if (want !== out_item) begin
            $display("%0t: digest mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d", $time,
                     want.digest_word, want.word_index, want.last_word,
                     out_item.digest_word, out_item.word_index, out_item.last_word);
            error_count <= error_count + 1;
          end
          if (want.last_word) digests_seen <= digests_seen + 1;
        end
      end
    end
  end

endmodule

/* bench/tb_sha256_hash_engine_core.sv */
// Testbench top for the SHA-256 byte-stream engine: clock, reset, byte stimulus, stalls, verdict.
// Depends on sha_pkg, sha_stream_if, sha_tb_pkg and sha256_digest_checker.
module tb_sha256_hash_engine_core;
  import sha_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 27;   // chance the sender holds off before a transfer
  int   recv_stall_pct = 72;  // chance the receiver drops ready in a cycle
  int   items_sent = 0;
  int   words_pending, error_count, digests_seen;

  always #4 clk = ~clk;

  sha_stream_if #(.payload_t(msg_item_t))    in_ch  (clk);
  sha_stream_if #(.payload_t(digest_item_t)) out_ch (clk);

  sha256_hash_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sha256_digest_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_item      (in_ch.payload),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_item     (out_ch.payload),
    .words_pending(words_pending),
    .error_count  (error_count),
    .digests_seen (digests_seen)
  );

  // Receiver: drop ready at random according to the current stall rate.
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one item and hold it until the engine takes the transfer.
  // Idle gaps lower valid first; back-to-back items keep valid high.
  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    msg_item_t it;
    it.data_byte = b;
    it.has_byte  = has;
    it.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    // ready is taken as it stands at the edge, before the engine updates
    @(posedge clk iff in_ch.ready);
    items_sent++;
    // Advance the idling schedule: receiver-heavy, then sender-heavy, then none.
    if (items_sent == 130) begin
      send_idle_pct = 72; recv_stall_pct = 27;
    end else if (items_sent == 250) begin
      send_idle_pct = 0; recv_stall_pct = 0;
    end
  endtask

  // Send a whole message of len random bytes; the end flag rides on the last byte
  // or comes as a separate empty item.
  task automatic send_message(input int len, input bit join_last);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, join_last && (k == len - 1));
    end
    if (!join_last || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, idle items, extreme bytes, byte carried with the end flag,
    // empty message again right after a digest.
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    // Hold the sender until every queued digest word has drained.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);

    // Padding boundaries: length just fits, spills into an extra block, full block.
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(64, 1'b1);

    // Random messages: half short, a third near the padding boundaries, the rest multi-block.
    while (items_sent < 360) begin
      case ($urandom_range(5))
        0:       len = $urandom_range(3);
        1, 2:    len = $urandom_range(20);
        3:       len = $urandom_range(57, 54);
        4:       len = $urandom_range(65, 62);
        default: len = $urandom_range(130, 100);
      endcase
      send_message(len, 1'($urandom_range(1)));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d byte-stream items; %0d complete digests checked across empty,",
             items_sent, digests_seen);
    $display("short, padding-boundary and multi-block messages under varied stalls.");
    if (error_count == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: generous bound on the whole run.
  initial begin
    #8ms;
    $display("Timeout with %0d digest words outstanding", words_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
